FILE: hw/rtl/card_number_luhn_validator_top_macros.svh
// Assertion helpers for the Luhn validator.
`ifndef CARD_NUMBER_LUHN_VALIDATOR_TOP_MACROS_SVH
`define CARD_NUMBER_LUHN_VALIDATOR_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CNLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the next edge.
`define CNLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cnlv_pkg.sv
`timescale 1ns / 1ps
package cnlv_pkg;

  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX       = 5'd31;
  localparam logic [CNT_W-1:0] MIN_LENGTH_RST  = 5'd13;
  localparam logic [CNT_W-1:0] MAX_LENGTH_RST  = 5'd16;

  localparam logic [DIGIT_W-1:0] PREFIX_FOUR   = 4'd4;
  localparam logic [DIGIT_W-1:0] PREFIX_FIVE   = 4'd5;
  localparam logic [DIGIT_W-1:0] PREFIX_SIX    = 4'd6;
  localparam logic [DIGIT_W-1:0] PREFIX_THREE  = 4'd3;
  localparam logic [DIGIT_W-1:0] PREFIX_SEVEN  = 4'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LENGTH = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             valid_res;
    logic             length_ok;
    logic             prefix_ok;
    logic             checksum_ok;
    logic [CNT_W-1:0] digit_count;
  } cnlv_res_t;

  // Doubled Luhn contribution: digit sum of 2d, modulo ten.
  function automatic logic [SUM_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
    logic [SUM_W-1:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      4'd10:   r = 4'd2;
      4'd11:   r = 4'd4;
      4'd12:   r = 4'd6;
      4'd13:   r = 4'd8;
      4'd14:   r = 4'd0;
      default: r = 4'd3;
    endcase
    return r;
  endfunction

  // Plain contribution: digit modulo ten.
  function automatic logic [SUM_W-1:0] luhn_plain(input logic [DIGIT_W-1:0] d);
    logic [SUM_W-1:0] r;
    r = (d >= 4'd10) ? SUM_W'(d - 4'd10) : SUM_W'(d);
    return r;
  endfunction

  // Sum of two values below ten, modulo ten.
  function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 5'd10) ? SUM_W'(s - 5'd10) : SUM_W'(s);
  endfunction

endpackage

FILE: hw/rtl/cnlv_in_if.sv
`timescale 1ns / 1ps
interface cnlv_in_if
  import cnlv_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

FILE: hw/rtl/cnlv_out_if.sv
`timescale 1ns / 1ps
interface cnlv_out_if
  import cnlv_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic             length_ok;
  logic             prefix_ok;
  logic             checksum_ok;
  logic [CNT_W-1:0] digit_count;

  modport source (output valid, output valid_res, output length_ok, output prefix_ok,
                  output checksum_ok, output digit_count, input ready);
  modport sink   (input valid, input valid_res, input length_ok, input prefix_ok,
                  input checksum_ok, input digit_count, output ready);
endinterface

FILE: hw/rtl/cnlv_core.sv
`timescale 1ns / 1ps
module cnlv_core
  import cnlv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               digit_take,
  input  logic [DIGIT_W-1:0] digit,
  input  logic               last_digit,
  input  logic [CNT_W-1:0]   min_length,
  input  logic [CNT_W-1:0]   max_length,
  output logic               res_push,
  output cnlv_res_t          res
);

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_even_r, sum_even_nxt;
  logic [SUM_W-1:0]   sum_odd_r, sum_odd_nxt;
  logic [DIGIT_W-1:0] lead_r, lead_nxt;
  logic [DIGIT_W-1:0] second_r, second_nxt;
  logic [SUM_W-1:0]   plain_c, dbl_c, sel_sum;

  assign plain_c = luhn_plain(digit);
  assign dbl_c   = luhn_double(digit);

  always_comb begin
    // Even positions from the first digit double into sum_even, odd into sum_odd.
    if (!count_r[0]) begin
      sum_even_nxt = add_mod10(sum_even_r, dbl_c);
      sum_odd_nxt  = add_mod10(sum_odd_r, plain_c);
    end else begin
      sum_even_nxt = add_mod10(sum_even_r, plain_c);
      sum_odd_nxt  = add_mod10(sum_odd_r, dbl_c);
    end
    lead_nxt   = (count_r == '0) ? digit : lead_r;
    second_nxt = (count_r == CNT_W'(1)) ? digit : second_r;
    count_nxt  = (count_r == COUNT_MAX) ? count_r : count_r + CNT_W'(1);

    sel_sum = count_nxt[0] ? sum_odd_nxt : sum_even_nxt;

    res.digit_count = count_nxt;
    res.length_ok   = (min_length <= count_nxt) && (count_nxt <= max_length);
    res.prefix_ok   = (lead_nxt == PREFIX_FOUR) || (lead_nxt == PREFIX_FIVE) ||
                      (lead_nxt == PREFIX_SIX) ||
                      ((count_nxt >= CNT_W'(2)) && (lead_nxt == PREFIX_THREE) &&
                       (second_nxt == PREFIX_SEVEN));
    res.checksum_ok = (sel_sum == '0);
    res.valid_res   = res.length_ok && res.prefix_ok && res.checksum_ok;
  end

  assign res_push = digit_take && last_digit;

  always_ff @(posedge clk) begin
    if (!rst_n || res_push) begin
      // Clear for the next number.
      count_r    <= '0;
      sum_even_r <= '0;
      sum_odd_r  <= '0;
      lead_r     <= '0;
      second_r   <= '0;
    end else if (digit_take) begin
      count_r    <= count_nxt;
      sum_even_r <= sum_even_nxt;
      sum_odd_r  <= sum_odd_nxt;
      lead_r     <= lead_nxt;
      second_r   <= second_nxt;
    end
  end

endmodule

FILE: hw/rtl/cnlv_out_buf.sv
`timescale 1ns / 1ps
module cnlv_out_buf
  import cnlv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cnlv_res_t push_data,
  output logic      has_room,
  output logic      out_valid,
  input  logic      out_ready,
  output cnlv_res_t out_data
);

  logic      main_v_r, skid_v_r;
  cnlv_res_t main_d_r, skid_d_r;
  logic      pop;

  assign pop       = main_v_r && out_ready;
  assign has_room  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        // Advance the skid entry; no push can arrive while it is full.
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_d_r <= skid_d_r;
    end else if (push && (pop || !main_v_r)) begin
      main_d_r <= push_data;
    end
    if (push && main_v_r && !pop) begin
      skid_d_r <= push_data;
    end
  end

endmodule

FILE: hw/rtl/card_number_luhn_validator_top.sv
`timescale 1ns / 1ps
// Luhn card-number validator: one decimal digit per beat, most significant first.
// Throughput: one digit per cycle while the result buffer has room; the mod-ten
// accumulate and the final tests sit in one level of logic between the running-sum
// registers and the result buffer, whose output register (or skid slot) takes the
// verdict of a number as its last digit is taken. Reset (rst_n, synchronous,
// active low): sums, count and buffer clear; min_length 13, max_length 16.
module card_number_luhn_validator_top
  import cnlv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cnlv_in_if.sink               in_ch,
  cnlv_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "card_number_luhn_validator_top_macros.svh"

  logic [CNT_W-1:0] min_length_r;
  logic [CNT_W-1:0] max_length_r;
  logic             digit_take;
  logic             res_push;
  logic             buf_room;
  cnlv_res_t        core_res;
  cnlv_res_t        out_res;

  // Configuration registers: write only while no number is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MIN_LENGTH_RST;
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LENGTH: min_length_r <= CNT_W'(cfg_wdata);
        CFG_MAX_LENGTH: max_length_r <= CNT_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Take a digit whenever the result buffer still has a free slot, so digits keep
  // flowing while a finished verdict waits downstream.
  assign in_ch.ready = buf_room;
  assign digit_take  = in_ch.valid && in_ch.ready;

  // Running sums, count and prefix capture; produces the verdict on the last digit.
  cnlv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .digit_take (digit_take),
    .digit      (in_ch.digit),
    .last_digit (in_ch.last_digit),
    .min_length (min_length_r),
    .max_length (max_length_r),
    .res_push   (res_push),
    .res        (core_res)
  );

  // Two-entry result buffer: the output register plus a skid slot.
  cnlv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (core_res),
    .has_room  (buf_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.valid_res   = out_res.valid_res;
  assign out_ch.length_ok   = out_res.length_ok;
  assign out_ch.prefix_ok   = out_res.prefix_ok;
  assign out_ch.checksum_ok = out_res.checksum_ok;
  assign out_ch.digit_count = out_res.digit_count;

  // The skid slot only fills behind an occupied output register.
  `CNLV_ASSERT(a_stall_implies_out, !in_ch.ready |-> out_ch.valid, "input stalled with empty output")
  // A last digit taken into an empty buffer shows up on the next edge.
  `CNLV_ASSERT_NEXT(a_last_to_out, digit_take && in_ch.last_digit && !out_ch.valid, out_ch.valid, "result lost")
  // Every reported number holds at least one digit.
  `CNLV_ASSERT(a_count_nonzero, out_ch.valid |-> (out_ch.digit_count != '0), "zero digit count reported")

endmodule

FILE: tb/luhn_verdict_checker.sv
`timescale 1ns / 1ps
module luhn_verdict_checker
  import cnlv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cnlv_in_if                    in_mon,
  cnlv_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           verdicts_owed
);

  logic [CNT_W-1:0]   min_len;
  logic [CNT_W-1:0]   max_len;
  logic [CNT_W-1:0]   digits_seen;
  logic [SUM_W-1:0]   sum_even;
  logic [SUM_W-1:0]   sum_odd;
  logic [DIGIT_W-1:0] lead;
  logic [DIGIT_W-1:0] second;
  cnlv_res_t          verdict_q[$];
  cnlv_res_t          want;
  int unsigned        fails;

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("%0t ns: luhn verdict %s mismatch: got %0d, want %0d", $time, what, got, exp_val);
    fails++;
  endtask

  task automatic clear_number();
    digits_seen = '0;
    sum_even    = '0;
    sum_odd     = '0;
    lead        = '0;
    second      = '0;
  endtask

  // Fold one accepted digit into the running sums; queue a verdict on the last one.
  task automatic fold_digit(input logic [DIGIT_W-1:0] d, input logic last);
    int        plain_v;
    int        dbl_v;
    int        twice;
    int        sel;
    cnlv_res_t r;
    plain_v = int'(d) % 10;
    twice   = 2 * int'(d);
    dbl_v   = ((twice % 10) + (twice / 10)) % 10;
    if (!digits_seen[0]) begin
      sum_even = SUM_W'((int'(sum_even) + dbl_v) % 10);
      sum_odd  = SUM_W'((int'(sum_odd) + plain_v) % 10);
    end else begin
      sum_even = SUM_W'((int'(sum_even) + plain_v) % 10);
      sum_odd  = SUM_W'((int'(sum_odd) + dbl_v) % 10);
    end
    if (digits_seen == 0) lead = d;
    else if (digits_seen == 1) second = d;
    if (digits_seen != COUNT_MAX) digits_seen++;
    if (last) begin
      sel           = digits_seen[0] ? int'(sum_odd) : int'(sum_even);
      r.length_ok   = (min_len <= digits_seen) && (digits_seen <= max_len);
      r.prefix_ok   = (lead == PREFIX_FOUR) || (lead == PREFIX_FIVE) || (lead == PREFIX_SIX) ||
                      (digits_seen >= 2 && lead == PREFIX_THREE && second == PREFIX_SEVEN);
      r.checksum_ok = (sel == 0);
      r.valid_res   = r.length_ok && r.prefix_ok && r.checksum_ok;
      r.digit_count = digits_seen;
      verdict_q.push_back(r);
      clear_number();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      min_len = MIN_LENGTH_RST;
      max_len = MAX_LENGTH_RST;
      clear_number();
      verdict_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MIN_LENGTH: min_len = cfg_wdata;
          CFG_MAX_LENGTH: max_len = cfg_wdata;
          default: ;
        endcase
      end
      // compare first: a verdict leaving now belongs to an earlier number
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("beat count", 1, 0);
        end else begin
          want = verdict_q.pop_front();
          if (out_mon.valid_res !== want.valid_res)
            flag_mismatch("valid_res", int'(out_mon.valid_res), int'(want.valid_res));
          if (out_mon.length_ok !== want.length_ok)
            flag_mismatch("length_ok", int'(out_mon.length_ok), int'(want.length_ok));
          if (out_mon.prefix_ok !== want.prefix_ok)
            flag_mismatch("prefix_ok", int'(out_mon.prefix_ok), int'(want.prefix_ok));
          if (out_mon.checksum_ok !== want.checksum_ok)
            flag_mismatch("checksum_ok", int'(out_mon.checksum_ok), int'(want.checksum_ok));
          if (out_mon.digit_count !== want.digit_count)
            flag_mismatch("digit_count", int'(out_mon.digit_count), int'(want.digit_count));
        end
      end
      if (in_mon.valid && in_mon.ready) fold_digit(in_mon.digit, in_mon.last_digit);
    end
    fail_count    <= fails;
    verdicts_owed <= verdict_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cnlv_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fail_count;
  int unsigned           verdicts_owed;

  // Stimulus state: the card number being built and how much has been sent.
  logic [DIGIT_W-1:0]    num_buf[64];
  int                    num_len;
  int                    digits_sent = 0;
  // Shared knobs: no_gaps runs both sides flat out; hold_off_req asks the
  // receiver for one long stall.
  bit                    no_gaps = 1'b0;
  bit                    hold_off_req = 1'b0;

  cnlv_in_if  in_ch ();
  cnlv_out_if out_ch ();

  card_number_luhn_validator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  luhn_verdict_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .verdicts_owed (verdicts_owed)
  );

  always #6 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offer one digit beat and hold it until the block takes it; then idle a while.
  // Valid is left high when no gap follows, so back-to-back beats never drop it.
  task automatic put_digit(input logic [DIGIT_W-1:0] d, input logic last);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.digit      <= d;
    in_ch.last_digit <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    digits_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_number(input int len);
    for (int i = 0; i < len; i++) put_digit(num_buf[i], i == len - 1);
  endtask

  // Drop valid and wait for every outstanding verdict, plus some margin, so the
  // block is idle before a register write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write both length limits, one register per cycle.
  task automatic set_lengths(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_LENGTH;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Build a random card number into num_buf. Most numbers get a real issuer
  // prefix, most a plausible length and most a correct check digit. The rest
  // are noise: odd lengths (down to one digit, up past saturation), bad check
  // digits and digits above nine.
  task automatic build_number();
    int   shape;
    int   s;
    int   twice;
    int   dist_r;
    int   dv;
    bit   wild;
    shape = $urandom_range(99);
    if (shape < 8)       num_len = $urandom_range(3, 1);
    else if (shape < 14) num_len = $urandom_range(40, 29);
    else if (shape < 20) num_len = $urandom_range(28, 20);
    else                 num_len = $urandom_range(19, 10);
    wild = ($urandom_range(99) < 12);
    for (int i = 0; i < num_len; i++)
      num_buf[i] = wild ? DIGIT_W'($urandom_range(15)) : DIGIT_W'($urandom_range(9));
    if ($urandom_range(99) < 80) begin
      case ($urandom_range(3))
        0: num_buf[0] = PREFIX_FOUR;
        1: num_buf[0] = PREFIX_FIVE;
        2: num_buf[0] = PREFIX_SIX;
        default: begin
          num_buf[0] = PREFIX_THREE;
          if (num_len > 1) num_buf[1] = PREFIX_SEVEN;
        end
      endcase
    end
    // Fix the check digit: double every second digit counting from the right.
    if (num_len <= 31 && $urandom_range(99) < 65) begin
      s = 0;
      for (int i = 0; i < num_len - 1; i++) begin
        dist_r = num_len - 1 - i;
        dv     = int'(num_buf[i]);
        twice  = 2 * dv;
        s = (s + ((dist_r % 2) ? ((twice % 10) + (twice / 10)) % 10 : dv % 10)) % 10;
      end
      num_buf[num_len-1] = DIGIT_W'((10 - s) % 10);
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = digits_sent;
    while (digits_sent - start < budget) begin
      build_number();
      send_number(num_len);
    end
  endtask

  // Receiver: random stalls and bursts, one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!no_gaps && $urandom_range(99) < 35) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat (no_gaps ? 1 : $urandom_range(12, 1)) @(posedge clk);
      end
    end
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("card_number_luhn_validator_top regression: fail");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.digit      <= '0;
    in_ch.last_digit <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_MIN_LENGTH;
    cfg_wdata        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed numbers under the reset limits (13..16).
    // A textbook valid 16-digit number starting with 4.
    num_buf[0] = 4'd4;
    for (int i = 1; i < 16; i++) num_buf[i] = 4'd1;
    send_number(16);
    // Single digits: prefix 4 alone, and a lone 3 that must not pass as 37.
    num_buf[0] = 4'd4;
    send_number(1);
    num_buf[0] = 4'd3;
    send_number(1);
    // Two-digit 37 prefix.
    num_buf[0] = 4'd3;
    num_buf[1] = 4'd7;
    send_number(2);
    // Digits above nine, all-ones bit pattern first.
    num_buf[0] = 4'd15;
    num_buf[1] = 4'd10;
    num_buf[2] = 4'd12;
    send_number(3);
    // Lone zero: the smallest digit, a zero Luhn sum.
    num_buf[0] = 4'd0;
    send_number(1);
    settle();

    // Widest window: everything from one to thirty-one digits passes length.
    set_lengths(5'd1, 5'd31);
    run_random(200);
    settle();

    // Only saturated numbers pass length; stall the receiver for a long
    // stretch so the result buffer fills and the input backs up.
    set_lengths(5'd31, 5'd31);
    hold_off_req = 1'b1;
    run_random(200);
    settle();

    // Inverted window: length never passes. Run both sides without gaps.
    set_lengths(5'd20, 5'd5);
    no_gaps = 1'b1;
    run_random(150);
    no_gaps = 1'b0;
    settle();

    // Zero minimum and a one-digit maximum.
    set_lengths(5'd0, 5'd1);
    run_random(120);
    settle();

    // Back to the usual card limits.
    set_lengths(MIN_LENGTH_RST, MAX_LENGTH_RST);
    run_random(200);
    settle();

    // Random windows until the digit budget is spent, half of them drawn from a sensible range.
    while (digits_sent < 1300) begin
      if ($urandom_range(1)) set_lengths(5'($urandom_range(16, 8)), 5'($urandom_range(24, 12)));
      else set_lengths(5'($urandom_range(31)), 5'($urandom_range(31)));
      run_random(130);
      settle();
    end

    // Drain and give the verdict.
    repeat (10) @(posedge clk);
    if (fail_count == 0 && verdicts_owed == 0) begin
      $display("card_number_luhn_validator_top regression: pass");
    end else begin
      $display("card_number_luhn_validator_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cnlv_pkg.sv
hw/rtl/cnlv_in_if.sv
hw/rtl/cnlv_out_if.sv
hw/rtl/cnlv_core.sv
hw/rtl/cnlv_out_buf.sv
hw/rtl/card_number_luhn_validator_top.sv
tb/luhn_verdict_checker.sv
tb/tb_top.sv
